/* rtl/crpg_pkg.sv */
// Shared types, codes and constants of the character row pixel generator.
// Holds the fixed palette, the RGB565 blend and the item and register codes.
// Depends on nothing.
package crpg_pkg;

  // Item kinds carried on the input tuser bit
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_CHARSET_UPPER      = 2'd0;
  localparam logic [1:0] REG_DRAWING_SUPPRESSED = 2'd1;
  localparam logic [1:0] REG_YELLOW             = 2'd2;
  localparam logic [1:0] REG_ORANGE             = 2'd3;

  localparam logic [15:0] YELLOW_RESET = 16'hFFE0;
  localparam logic [15:0] ORANGE_RESET = 16'hFDA0;

  localparam logic [8:0]  ORIGIN_X     = 9'd28;
  localparam logic [7:0]  ORIGIN_Y     = 8'd28;
  localparam logic [12:0] UPPER_OFFSET = 13'd2048;

  // Position of a pixel inside its row: four bit pairs, three pixels each
  localparam logic [1:0] LAST_PAIR  = 2'd3;
  localparam logic [1:0] PHASE_LEFT = 2'd0;
  localparam logic [1:0] PHASE_MID  = 2'd1;
  localparam logic [1:0] PHASE_RIGHT = 2'd2;

  typedef logic [15:0] rgb565_t;

  function automatic rgb565_t palette(input logic [3:0] idx, input rgb565_t yellow,
                                      input rgb565_t orange);
    rgb565_t c;
    case (idx)
      4'd0:    c = 16'h0000;
      4'd1:    c = 16'hFFFF;
      4'd2:    c = 16'h8800;
      4'd3:    c = 16'hA77E;
      4'd4:    c = 16'h8118;
      4'd5:    c = 16'h3E03;
      4'd6:    c = 16'h0015;
      4'd7:    c = yellow;
      4'd8:    c = orange;
      4'd9:    c = 16'hFFFA;
      4'd10:   c = 16'hFC10;
      4'd11:   c = 16'hB73F;
      4'd12:   c = 16'hF61F;
      4'd13:   c = 16'hBFF7;
      4'd14:   c = 16'hB73F;
      default: c = 16'hDF50;
    endcase
    return c;
  endfunction

  // Channel-wise floor average of two RGB565 colors
  function automatic rgb565_t blend565(input rgb565_t a, input rgb565_t b);
    logic [5:0] r;
    logic [6:0] g;
    logic [5:0] bl;
    r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
    g  = {1'b0, a[10:5]} + {1'b0, b[10:5]};
    bl = {1'b0, a[4:0]} + {1'b0, b[4:0]};
    return {r[5:1], g[6:1], bl[5:1]};
  endfunction

endpackage

/* rtl/char_row_pixel_generator_3to2.sv */
// Text-mode character row renderer with 3:2 horizontal scaling, RGB565 out.
// Glyph store, read pipeline and pixel sequencer in one module.
// Depends on crpg_pkg.

// A load item (tuser = 0) writes one byte of the glyph store in the cycle it
// is accepted and gives no pixels. A draw item (tuser = 1) reads one glyph
// byte and gives twelve pixels of one screen row, left to right, tlast set
// on the twelfth; a draw item that is suppressed or names a cell off screen
// gives nothing. Pixels leave at one per cycle while the master side is
// ready, so the pixel sequencer sets the sustained rate of draw items; a
// load or a dropped draw item passes without occupying the sequencer.
// Items pass through a glyph-read register and a pixel sequencer, and an
// output register parts the sequencer from the master side, so the next
// item is taken while the current row is still being sent. The glyph store
// has no reset: draw only glyph bytes that have been loaded. Write the
// configuration only while no item is in flight.
module char_row_pixel_generator_3to2 #(
  parameter int GLYPH_STORE_DEPTH = 4096,
  parameter int SCREEN_COLUMNS    = 22,
  parameter int SCREEN_ROWS       = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  // slave side
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata from bit 0: glyph_addr[11:0], glyph_data[19:12], char_code[27:20],
  // text_col[32:28], text_row[37:33], glyph_row[40:38], fg_index[44:41],
  // bg_index[48:45], zero fill [55:49]
  input  logic [55:0]          s_tdata,
  // s_tuser: opcode
  input  logic                 s_tuser,
  // master side
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata from bit 0: pixel_x[8:0], pixel_y[16:9], pixel_color[32:17],
  // zero fill [39:33]
  output logic [39:0]          m_tdata,
  // m_tlast: last_in_row
  output logic                 m_tlast,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import crpg_pkg::*;

  localparam int AW = $clog2(GLYPH_STORE_DEPTH);
  localparam logic [12:0] DEPTH13 = 13'(GLYPH_STORE_DEPTH);
  localparam logic [4:0]  COLS5   = 5'(SCREEN_COLUMNS);
  localparam logic [4:0]  ROWS5   = 5'(SCREEN_ROWS);

  // Addresses stay below twice the depth, so one subtract wraps them
  function automatic logic [12:0] wrap_addr(input logic [12:0] a);
    return (a >= DEPTH13) ? (a - DEPTH13) : a;
  endfunction

  // Input fields
  logic [11:0] in_glyph_addr;
  logic [7:0]  in_glyph_data;
  logic [7:0]  in_char_code;
  logic [4:0]  in_text_col;
  logic [4:0]  in_text_row;
  logic [2:0]  in_glyph_row;
  logic [3:0]  in_fg_index;
  logic [3:0]  in_bg_index;

  assign in_glyph_addr = s_tdata[11:0];
  assign in_glyph_data = s_tdata[19:12];
  assign in_char_code  = s_tdata[27:20];
  assign in_text_col   = s_tdata[32:28];
  assign in_text_row   = s_tdata[37:33];
  assign in_glyph_row  = s_tdata[40:38];
  assign in_fg_index   = s_tdata[44:41];
  assign in_bg_index   = s_tdata[48:45];

  // Configuration registers
  logic    charset_upper;
  logic    drawing_suppressed;
  rgb565_t yellow_rgb565;
  rgb565_t orange_rgb565;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset_upper      <= 1'b0;
      drawing_suppressed <= 1'b0;
      yellow_rgb565      <= YELLOW_RESET;
      orange_rgb565      <= ORANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHARSET_UPPER:      charset_upper      <= cfg_data[0];
        REG_DRAWING_SUPPRESSED: drawing_suppressed <= cfg_data[0];
        REG_YELLOW:             yellow_rgb565      <= cfg_data;
        REG_ORANGE:             orange_rgb565      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Glyph-read stage
  logic          a_valid;
  logic [3:0]    a_fg_index;
  logic [3:0]    a_bg_index;
  logic [8:0]    a_x0;
  logic [7:0]    a_y;
  logic [7:0]    glyph_q;
  logic          a_move;

  // Pixel sequencer stage
  logic          b_valid;
  logic [7:0]    b_bits;
  rgb565_t       b_fg;
  rgb565_t       b_bg;
  logic [8:0]    b_x;
  logic [7:0]    b_y;
  logic [1:0]    b_pair;
  logic [1:0]    b_phase;
  logic          b_last;
  logic          b_step;

  logic          out_free;
  logic          in_accept;
  logic          take_load;
  logic          take_draw;
  logic [12:0]   rd_addr;
  logic [12:0]   wr_addr;
  logic [8:0]    x0_next;
  logic [7:0]    y_next;

  logic [7:0]    bits_sh;
  rgb565_t       color_a;
  rgb565_t       color_b;
  rgb565_t       pixel_color;

  logic [7:0]    glyph_mem [GLYPH_STORE_DEPTH];

  assign out_free = !m_tvalid || m_tready;
  assign b_last   = (b_pair == LAST_PAIR) && (b_phase == PHASE_RIGHT);
  assign b_step   = b_valid && out_free;
  // Hand the fetched glyph to the sequencer once it is empty or finishing
  assign a_move   = a_valid && (!b_valid || (b_step && b_last));
  assign s_tready = !a_valid || a_move;

  assign in_accept = s_tvalid && s_tready;
  assign take_load = in_accept && (s_tuser == OP_LOAD);
  // Drop suppressed and off-screen draw items right at the input
  assign take_draw = in_accept && (s_tuser == OP_DRAW) && !drawing_suppressed &&
                     (in_text_col < COLS5) && (in_text_row < ROWS5);

  assign rd_addr = wrap_addr({2'b00, in_char_code, in_glyph_row} +
                             (charset_upper ? UPPER_OFFSET : 13'd0));
  assign wr_addr = wrap_addr({1'b0, in_glyph_addr});

  // x0 = 28 + col*12, y = 28 + row*8 + glyph row
  assign x0_next = ORIGIN_X + {1'b0, in_text_col, 3'b000} + {2'b00, in_text_col, 2'b00};
  assign y_next  = ORIGIN_Y + {in_text_row, in_glyph_row};

  // Glyph store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (take_load) begin
      glyph_mem[wr_addr[AW-1:0]] <= in_glyph_data;
    end
    if (take_draw) begin
      glyph_q <= glyph_mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take_draw) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_draw) begin
      a_fg_index <= in_fg_index;
      a_bg_index <= in_bg_index;
      a_x0       <= x0_next;
      a_y        <= y_next;
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_pair  <= 2'd0;
      b_phase <= PHASE_LEFT;
    end else if (a_move) begin
      b_valid <= 1'b1;
      b_pair  <= 2'd0;
      b_phase <= PHASE_LEFT;
    end else if (b_step) begin
      if (b_last) begin
        b_valid <= 1'b0;
      end else if (b_phase == PHASE_RIGHT) begin
        b_phase <= PHASE_LEFT;
        b_pair  <= b_pair + 2'd1;
      end else begin
        b_phase <= b_phase + 2'd1;
      end
    end
  end

  // Sequencer payload: map the palette once per row
  always_ff @(posedge clk) begin
    if (a_move) begin
      b_bits <= glyph_q;
      b_fg   <= palette(a_fg_index, yellow_rgb565, orange_rgb565);
      b_bg   <= palette(a_bg_index, yellow_rgb565, orange_rgb565);
      b_x    <= a_x0;
      b_y    <= a_y;
    end else if (b_step) begin
      b_x    <= b_x + 9'd1;
    end
  end

  // Current bit pair moves to the top of the byte
  assign bits_sh = b_bits << {b_pair, 1'b0};
  assign color_a = bits_sh[7] ? b_fg : b_bg;
  assign color_b = bits_sh[6] ? b_fg : b_bg;

  always_comb begin
    case (b_phase)
      PHASE_LEFT: pixel_color = color_a;
      PHASE_MID:  pixel_color = (color_a == color_b) ? color_b : blend565(color_b, color_a);
      default:    pixel_color = color_b;
    endcase
  end

  // Output register: advance when the master side is free, hold otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_step) begin
      m_tdata <= {7'd0, pixel_color, b_y, b_x};
      m_tlast <= b_last;
    end
  end

endmodule

/* sim/char_row_pixel_generator_3to2_test.sv */
// Self-checking testbench of char_row_pixel_generator_3to2: glyph loads, drawn rows,
// charset and suppression registers, palette registers and output back-pressure.
// Depends on crpg_pkg and the char_row_pixel_generator_3to2 RTL.
module char_row_pixel_generator_3to2_test;
  import crpg_pkg::*;

  localparam int SCREEN_COLS     = 22;
  localparam int SCREEN_ROWS_N   = 23;
  localparam int IDLE_CYCLES     = 30;   // beyond the deepest pipeline fill
  localparam int HOLD_CYCLES     = 300;  // long receiver hold-off
  localparam logic [15:0] YELLOW_AT_RESET = 16'hFFE0;
  localparam logic [15:0] ORANGE_AT_RESET = 16'hFDA0;

  // One expected pixel, as it leaves the master side
  typedef struct packed {
    logic [8:0]  x;
    logic [7:0]  y;
    logic [15:0] color;
    logic        row_end;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Mirror of the block's state and registers
  logic [7:0]  glyph_copy [4096];
  bit          glyph_loaded [4096];
  logic [11:0] lo_glyphs [$];   // loaded addresses in the lower charset half
  logic [11:0] hi_glyphs [$];   // loaded addresses in the upper charset half
  logic        upper_copy = 1'b0;
  logic        suppress_copy = 1'b0;
  logic [15:0] yellow_copy = YELLOW_AT_RESET;
  logic [15:0] orange_copy = ORANGE_AT_RESET;

  pixel_t pending_pixels [$];
  int     mismatch_count = 0;

  // Sender pacing
  int burst_left = 0;
  bit gaps_enabled = 1'b1;

  // Receiver pacing; a toggle of hold_toggle asks for one long hold-off
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   rx_cycle = 0;
  int   stretch;
  pixel_t got, want;

  char_row_pixel_generator_3to2 dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Palette lookup with the two programmable entries taken from the mirror
  function automatic logic [15:0] color_of(input logic [3:0] idx);
    logic [15:0] c;
    case (idx)
      4'd0:    c = 16'h0000;
      4'd1:    c = 16'hFFFF;
      4'd2:    c = 16'h8800;
      4'd3:    c = 16'hA77E;
      4'd4:    c = 16'h8118;
      4'd5:    c = 16'h3E03;
      4'd6:    c = 16'h0015;
      4'd7:    c = yellow_copy;
      4'd8:    c = orange_copy;
      4'd9:    c = 16'hFFFA;
      4'd10:   c = 16'hFC10;
      4'd11:   c = 16'hB73F;
      4'd12:   c = 16'hF61F;
      4'd13:   c = 16'hBFF7;
      4'd14:   c = 16'hB73F;
      default: c = 16'hDF50;
    endcase
    return c;
  endfunction

  // Floor average per channel: 5-bit red, 6-bit green, 5-bit blue
  function automatic logic [15:0] mix565(input logic [15:0] a, input logic [15:0] b);
    int r, g, bl;
    r  = (int'(a[15:11]) + int'(b[15:11])) / 2;
    g  = (int'(a[10:5]) + int'(b[10:5])) / 2;
    bl = (int'(a[4:0]) + int'(b[4:0])) / 2;
    return {r[4:0], g[5:0], bl[4:0]};
  endfunction

  // Queue the twelve pixels that a draw item yields, if any
  function automatic void render_row(input logic [55:0] d);
    logic [11:0] addr;
    logic [7:0]  bits;
    logic [15:0] fg, bg, c, left;
    logic [4:0]  col, row;
    logic [2:0]  grow;
    int          i, bit_pos;
    pixel_t      px;
    col  = d[32:28];
    row  = d[37:33];
    grow = d[40:38];
    if (suppress_copy || int'(col) >= SCREEN_COLS || int'(row) >= SCREEN_ROWS_N) return;
    // 11-bit offset plus the upper-half offset wraps in 12 bits
    addr = {1'b0, d[27:20], grow} + (upper_copy ? 12'd2048 : 12'd0);
    bits = glyph_copy[addr];
    fg   = color_of(d[44:41]);
    bg   = color_of(d[48:45]);
    left = '0;
    for (i = 0; i < 12; i++) begin
      // each bit pair (a, b) becomes color(a), mid, color(b)
      bit_pos = 7 - (i / 3) * 2 - ((i % 3 == 0) ? 0 : 1);
      c = bits[bit_pos] ? fg : bg;
      if (i % 3 == 1) begin
        if (c != left) c = mix565(c, left);
      end else begin
        left = c;
      end
      px.x       = 9'(28 + int'(col) * 12 + i);
      px.y       = 8'(28 + int'(row) * 8 + int'(grow));
      px.color   = c;
      px.row_end = (i == 11);
      pending_pixels.push_back(px);
    end
  endfunction

  // Offer one item in the current burst, hold it until accepted, then predict
  task automatic send_item(input logic op, input logic [55:0] data);
    int          gap;
    logic [11:0] a;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_enabled ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_LOAD) begin
      a = data[11:0];
      if (!glyph_loaded[a]) begin
        glyph_loaded[a] = 1'b1;
        if (a[11]) hi_glyphs.push_back(a);
        else lo_glyphs.push_back(a);
      end
      glyph_copy[a] = data[19:12];
    end else begin
      render_row(data);
    end
  endtask

  // Load item; the draw fields carry junk that the block must ignore
  task automatic send_load(input logic [11:0] addr, input logic [7:0] value);
    logic [28:0] junk;
    junk = 29'($urandom);
    send_item(OP_LOAD, {7'd0, junk, value, addr});
  endtask

  // Draw item; the load fields carry junk that the block must ignore
  task automatic send_draw(input logic [7:0] code, input logic [2:0] grow,
                           input logic [4:0] col, input logic [4:0] row,
                           input logic [3:0] fg, input logic [3:0] bg);
    logic [19:0] junk;
    junk = 20'($urandom);
    send_item(OP_DRAW, {7'd0, bg, fg, grow, row, col, code, junk});
  endtask

  // Pick a loaded glyph address in the half the charset register selects
  function automatic bit pick_glyph(output logic [11:0] a);
    a = '0;
    if (upper_copy) begin
      if (hi_glyphs.size() == 0) return 1'b0;
      a = hi_glyphs[$urandom_range(0, hi_glyphs.size() - 1)];
    end else begin
      if (lo_glyphs.size() == 0) return 1'b0;
      a = lo_glyphs[$urandom_range(0, lo_glyphs.size() - 1)];
    end
    return 1'b1;
  endfunction

  // Drop valid, wait out every expected pixel, then let trailing loads settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all four registers; call only while the block is idle
  task automatic configure(input logic up, input logic sup,
                           input logic [15:0] yel, input logic [15:0] org);
    put_reg(REG_CHARSET_UPPER, {15'd0, up});
    put_reg(REG_DRAWING_SUPPRESSED, {15'd0, sup});
    put_reg(REG_YELLOW, yel);
    put_reg(REG_ORANGE, org);
    cfg_valid <= 1'b0;
    upper_copy    = up;
    suppress_copy = sup;
    yellow_copy   = yel;
    orange_copy   = org;
  endtask

  // Extremes of the fields, blends and equal colors, off-screen cells,
  // and a draw right behind a load of the same byte
  task automatic test_directed_rows();
    send_load(12'h000, 8'hA5);
    send_load(12'h7FF, 8'hFF);
    send_load(12'h800, 8'h0F);
    send_load(12'hFFF, 8'h3C);
    send_draw(8'd0, 3'd0, 5'd0, 5'd0, 4'd1, 4'd0);
    send_draw(8'd255, 3'd7, 5'd21, 5'd22, 4'd7, 4'd8);
    send_draw(8'd0, 3'd0, 5'd5, 5'd9, 4'd4, 4'd4);
    send_draw(8'd0, 3'd0, 5'd10, 5'd3, 4'd15, 4'd14);
    // off screen: column, row, both
    send_draw(8'd0, 3'd0, 5'd22, 5'd0, 4'd1, 4'd0);
    send_draw(8'd0, 3'd0, 5'd0, 5'd23, 4'd1, 4'd0);
    send_draw(8'd0, 3'd0, 5'd31, 5'd31, 4'd1, 4'd0);
    send_load(12'h000, 8'h5A);
    send_draw(8'd0, 3'd0, 5'd1, 5'd1, 4'd9, 4'd2);
    drain();
  endtask

  task automatic test_charset_upper();
    configure(1'b1, 1'b0, YELLOW_AT_RESET, ORANGE_AT_RESET);
    send_draw(8'd0, 3'd0, 5'd2, 5'd4, 4'd12, 4'd3);
    send_draw(8'd255, 3'd7, 5'd21, 5'd0, 4'd5, 4'd6);
    drain();
  endtask

  task automatic test_suppression();
    configure(1'b0, 1'b1, YELLOW_AT_RESET, ORANGE_AT_RESET);
    send_draw(8'd0, 3'd0, 5'd3, 5'd3, 4'd1, 4'd0);
    send_draw(8'd255, 3'd7, 5'd0, 5'd0, 4'd10, 4'd11);
    drain();
  endtask

  task automatic test_palette_registers();
    configure(1'b0, 1'b0, 16'h0000, 16'hFFFF);
    send_draw(8'd0, 3'd0, 5'd4, 5'd5, 4'd7, 4'd8);
    drain();
    configure(1'b0, 1'b0, 16'hFFFF, 16'h0000);
    send_draw(8'd0, 3'd0, 5'd6, 5'd7, 4'd8, 4'd7);
    drain();
  endtask

  // Hold the receiver off while draws keep coming, so the input side stalls
  task automatic test_output_stall();
    logic [11:0] a;
    int          n;
    hold_toggle <= ~hold_toggle;
    gaps_enabled = 1'b0;
    for (n = 0; n < 20; n++) begin
      if (pick_glyph(a))
        send_draw(a[10:3], a[2:0], 5'($urandom_range(0, 21)), 5'($urandom_range(0, 22)),
                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
    gaps_enabled = 1'b1;
    drain();
  endtask

  task automatic random_items(input int count);
    int          roll, col, row;
    logic [11:0] a;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 25 || !pick_glyph(a)) begin
        send_load(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
      end else begin
        col = $urandom_range(0, SCREEN_COLS - 1);
        row = $urandom_range(0, SCREEN_ROWS_N - 1);
        // a slice of draws lands off screen
        if (roll < 31) col = $urandom_range(SCREEN_COLS, 31);
        else if (roll < 37) row = $urandom_range(SCREEN_ROWS_N, 31);
        send_draw(a[10:3], a[2:0], col[4:0], row[4:0],
                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end
    end
    drain();
  endtask

  // Random traffic over several register settings, extremes among them
  task automatic test_random_traffic();
    configure(1'b0, 1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    random_items(64);
    configure(1'b1, 1'b0, 16'h0000, 16'hFFFF);
    random_items(64);
    configure(1'b0, 1'b1, 16'hFFFF, 16'h0000);
    random_items(32);
    // stretch without sender gaps
    configure(1'b1, 1'b0, 16'hFFFF, 16'h0000);
    gaps_enabled = 1'b0;
    random_items(64);
    gaps_enabled = 1'b1;
    configure(1'b0, 1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    random_items(60);
  endtask

  // Receiver: check each accepted pixel, then choose next cycle's ready
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      got.x       = m_tdata[8:0];
      got.y       = m_tdata[16:9];
      got.color   = m_tdata[32:17];
      got.row_end = m_tlast;
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel with nothing expected: x=%0d y=%0d color=%h last=%b",
                 $time, got.x, got.y, got.color, got.row_end);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: pixel_x expected %0d got %0d", $time, want.x, got.x);
          mismatch_count++;
        end
        if (got.y !== want.y) begin
          $display("%0t: pixel_y expected %0d got %0d", $time, want.y, got.y);
          mismatch_count++;
        end
        if (got.color !== want.color) begin
          $display("%0t: pixel_color expected %h got %h", $time, want.color, got.color);
          mismatch_count++;
        end
        if (got.row_end !== want.row_end) begin
          $display("%0t: last_in_row expected %b got %b", $time, want.row_end, got.row_end);
          mismatch_count++;
        end
      end
    end

    rx_cycle <= rx_cycle + 1;
    stretch = (rx_cycle / 97) % 4;
    if (hold_toggle != hold_seen) begin
      // start the long hold-off
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (stretch == 0) begin
      m_tready <= 1'b1;                    // no stalls
    end else if (stretch == 1) begin
      m_tready <= (rx_cycle % 5) != 0;     // stall one cycle in five
    end else if (stretch == 2) begin
      m_tready <= 1'($urandom_range(0, 1));
    end else begin
      m_tready <= (rx_cycle % 3) == 0;     // ready one cycle in three
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_rows();
    test_charset_upper();
    test_suppression();
    test_palette_registers();
    test_output_stall();
    test_random_traffic();
    repeat (IDLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("char_row_pixel_generator_3to2 regression: pass");
    end else begin
      $display("char_row_pixel_generator_3to2 regression: fail");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run
  initial begin
    #2000000;
    $display("char_row_pixel_generator_3to2 regression: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/crpg_pkg.sv
rtl/char_row_pixel_generator_3to2.sv
sim/char_row_pixel_generator_3to2_test.sv
